### design/pfu_pkg.sv
package pfu_pkg;

    typedef enum logic [2:0] {
        FMT_I420    = 3'd0,
        FMT_NV12    = 3'd1,
        FMT_BGRA    = 3'd2,
        FMT_BGRX    = 3'd3,
        FMT_RGBA    = 3'd4,
        FMT_YUY2    = 3'd5,
        FMT_UYVY    = 3'd6,
        FMT_UNKNOWN = 3'd7
    } t_pix_fmt;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 19;

    typedef logic signed [SUM_W-1:0] t_sum;

    // BT.601 integer coefficients, scaled by 256.
    localparam t_sum K_Y    = 19'sd298;
    localparam t_sum K_RV   = 19'sd409;
    localparam t_sum K_GU   = 19'sd100;
    localparam t_sum K_GV   = 19'sd208;
    localparam t_sum K_BU   = 19'sd516;
    localparam t_sum K_RND  = 19'sd128;
    localparam logic [8:0] Y_OFFSET = 9'd16;
    localparam logic [7:0] C_OFFSET = 8'h80;

    // Unpacked pixel carried from the select stage to the conversion stage.
    typedef struct packed {
        logic                     is_yuv;
        logic signed [8:0]        c;
        logic signed [7:0]        d;
        logic signed [7:0]        e;
        logic [BYTE_W-1:0]        red;
        logic [BYTE_W-1:0]        green;
        logic [BYTE_W-1:0]        blue;
    } t_unpacked;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

endpackage

### design/pfu_unpack.sv
module pfu_unpack (
    input  pfu_pkg::t_pix_fmt  i_fmt,
    input  logic [7:0]         i_byte0,
    input  logic [7:0]         i_byte1,
    input  logic [7:0]         i_byte2,
    input  logic [7:0]         i_byte3,
    input  logic               i_column_odd,
    output pfu_pkg::t_unpacked o_pix
);

    logic       yuv;
    logic [7:0] y_sel;
    logic [7:0] u_sel;
    logic [7:0] v_sel;
    logic [7:0] r_sel;
    logic [7:0] g_sel;
    logic [7:0] b_sel;

    always_comb begin
        yuv   = 1'b0;
        y_sel = i_byte0;
        u_sel = i_byte1;
        v_sel = i_byte2;
        r_sel = 8'd0;
        g_sel = 8'd0;
        b_sel = 8'd0;
        case (i_fmt)
            pfu_pkg::FMT_I420, pfu_pkg::FMT_NV12: begin
                yuv = 1'b1;
            end
            pfu_pkg::FMT_BGRA, pfu_pkg::FMT_BGRX: begin
                r_sel = i_byte2;
                g_sel = i_byte1;
                b_sel = i_byte0;
            end
            pfu_pkg::FMT_RGBA: begin
                r_sel = i_byte0;
                g_sel = i_byte1;
                b_sel = i_byte2;
            end
            pfu_pkg::FMT_YUY2: begin
                yuv   = 1'b1;
                y_sel = i_column_odd ? i_byte2 : i_byte0;
                u_sel = i_byte1;
                v_sel = i_byte3;
            end
            pfu_pkg::FMT_UYVY: begin
                yuv   = 1'b1;
                y_sel = i_column_odd ? i_byte3 : i_byte1;
                u_sel = i_byte0;
                v_sel = i_byte2;
            end
            default: begin
                // Unknown format leaves the pixel black.
                yuv = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_pix.is_yuv = yuv;
        o_pix.c      = $signed({1'b0, y_sel} - pfu_pkg::Y_OFFSET);
        o_pix.d      = $signed(u_sel ^ pfu_pkg::C_OFFSET);
        o_pix.e      = $signed(v_sel ^ pfu_pkg::C_OFFSET);
        o_pix.red    = r_sel;
        o_pix.green  = g_sel;
        o_pix.blue   = b_sel;
    end

endmodule

### design/pfu_convert.sv
module pfu_convert (
    input  pfu_pkg::t_unpacked i_pix,
    output pfu_pkg::t_rgb      o_rgb
);

    pfu_pkg::t_sum luma;
    pfu_pkg::t_sum sum_r;
    pfu_pkg::t_sum sum_g;
    pfu_pkg::t_sum sum_b;

    // Negative sums go to zero; anything at or above 256 after the shift saturates.
    function automatic logic [7:0] clamp_byte(input pfu_pkg::t_sum s);
        logic [7:0] res;
        if (s[pfu_pkg::SUM_W-1]) begin
            res = 8'd0;
        end else if (s[pfu_pkg::SUM_W-2:16] != '0) begin
            res = 8'hFF;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    always_comb begin
        luma  = pfu_pkg::t_sum'(i_pix.c) * pfu_pkg::K_Y + pfu_pkg::K_RND;
        sum_r = luma + pfu_pkg::t_sum'(i_pix.e) * pfu_pkg::K_RV;
        sum_g = luma - pfu_pkg::t_sum'(i_pix.d) * pfu_pkg::K_GU
                     - pfu_pkg::t_sum'(i_pix.e) * pfu_pkg::K_GV;
        sum_b = luma + pfu_pkg::t_sum'(i_pix.d) * pfu_pkg::K_BU;
    end

    always_comb begin
        if (i_pix.is_yuv) begin
            o_rgb.red   = clamp_byte(sum_r);
            o_rgb.green = clamp_byte(sum_g);
            o_rgb.blue  = clamp_byte(sum_b);
        end else begin
            o_rgb.red   = i_pix.red;
            o_rgb.green = i_pix.green;
            o_rgb.blue  = i_pix.blue;
        end
    end

endmodule

### design/pixel_format_unpack_to_rgb_top.sv
// An accepted input item is held in the select register and then in the result register.
// Throughput: one item per clock; the select register and the result register
// form a two-stage pipeline that only stalls when the output is held off.
// Reset (synchronous, active low) empties both stages and sets the pixel
// format to I420; payload registers are not reset.
module pixel_format_unpack_to_rgb_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,   // pixel_format
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // src_byte0, src_byte1, src_byte2, src_byte3
    input  logic [0:0]  s_axis_tuser,    // column_odd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // red, green, blue
);

    pfu_pkg::t_pix_fmt  r_pixel_format;
    pfu_pkg::t_unpacked n_s1;
    pfu_pkg::t_unpacked r_s1;
    logic               r_v1;
    pfu_pkg::t_rgb      n_s2;
    pfu_pkg::t_rgb      r_s2;
    logic               r_v2;
    logic               adv2;
    logic               adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= pfu_pkg::FMT_I420;
        end else if (i_cfg_wr_en) begin
            r_pixel_format <= pfu_pkg::t_pix_fmt'(i_cfg_wr_data);
        end
    end

    pfu_unpack u_unpack (
        .i_fmt        (r_pixel_format),
        .i_byte0      (s_axis_tdata[7:0]),
        .i_byte1      (s_axis_tdata[15:8]),
        .i_byte2      (s_axis_tdata[23:16]),
        .i_byte3      (s_axis_tdata[31:24]),
        .i_column_odd (s_axis_tuser[0]),
        .o_pix        (n_s1)
    );

    pfu_convert u_convert (
        .i_pix (r_s1),
        .o_rgb (n_s2)
    );

    assign adv2          = !r_v2 || m_axis_tready;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (adv2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {r_s2.blue, r_s2.green, r_s2.red};

endmodule

### design/pfu_checker.sv
module pfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // The output stage is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A held result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Every accepted item is expected to show up at the output once it has passed both pipeline registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // The input side never stalls while the output side is draining.
    a_no_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled although output is ready");

    // An empty output stage always leaves room for a new item.
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled although pipeline has room");

endmodule

bind pixel_format_unpack_to_rgb_top pfu_checker u_pfu_checker (.*);
